/* src/lage_pkg.sv */
// Shared types and operation codes for the life automaton grid engine.
`timescale 1ns / 1ps

package lage_pkg;

  localparam logic [1:0] OP_INSPECT = 2'd0;
  localparam logic [1:0] OP_TOGGLE  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] row_index;
    logic [6:0] col_index;
  } req_word_t;

  typedef struct packed {
    logic        cell_alive;
    logic [31:0] generation_count;
  } rsp_word_t;

endpackage

/* src/lage_grid_mem.sv */
// Grid row memory with per-row valid bits so that reset reads as an empty grid.
`timescale 1ns / 1ps

module lage_grid_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [COLS-1:0]         wdata,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [COLS-1:0]         rdata
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [COLS-1:0] rd_word;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word  <= mem[raddr];
    rd_valid <= row_valid[raddr] && !rst;
  end

  // A row never written since reset holds only dead cells.
  assign rdata = rd_valid ? rd_word : '0;

endmodule

/* src/lage_row_unit.sv */
// Next-generation logic for one grid row from the rows above and below (B3/S23).
`timescale 1ns / 1ps

module lage_row_unit #(
  parameter int COLS = 128
) (
  input  logic [COLS-1:0] row_above,
  input  logic [COLS-1:0] row_mid,
  input  logic [COLS-1:0] row_below,
  output logic [COLS-1:0] row_next
);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Dead cells pad both edges, so there is no wrap-around.
  logic [COLS+1:0] up_x;
  logic [COLS+1:0] mid_x;
  logic [COLS+1:0] dn_x;
  logic [3:0]      count [COLS];

  assign up_x  = {1'b0, row_above, 1'b0};
  assign mid_x = {1'b0, row_mid, 1'b0};
  assign dn_x  = {1'b0, row_below, 1'b0};

  for (genvar i = 0; i < COLS; i++) begin : g_col
    assign count[i] = 4'(up_x[i]) + 4'(up_x[i+1]) + 4'(up_x[i+2])
                    + 4'(mid_x[i]) + 4'(mid_x[i+2])
                    + 4'(dn_x[i]) + 4'(dn_x[i+1]) + 4'(dn_x[i+2]);
    assign row_next[i] = (count[i] == BIRTH_COUNT)
                       || (row_mid[i] && (count[i] == SURVIVE_COUNT));
  end

endmodule

/* src/life_automaton_grid_engine_top.sv */
// Top level: command sequencer around the grid memory and the shared row unit.
// Inspect and toggle: the row is read (S_READ, S_CELL), then the response word is registered.
// Advance: a sweep of every row through the row unit, then the cell is read as for inspect.
// One word is in flight; the next is taken the cycle after the response leaves,
// so a new request waits until the response to the last one is accepted.
// Synchronous reset empties the grid (row valid bits) and zeroes the counter.
`timescale 1ns / 1ps

module life_automaton_grid_engine_top
  import lage_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int SW = $clog2(GRID_ROWS + 2);
  localparam logic [SW-1:0] ROWS_S     = SW'(GRID_ROWS);
  localparam logic [SW-1:0] SWEEP_LAST = SW'(GRID_ROWS + 1);
  localparam logic [SW-1:0] WRITE_LAG  = SW'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_CELL,
    S_RESP
  } state_t;

  state_t          state;
  logic [SW-1:0]   step;
  logic [GRID_COLS-1:0] prev_row;
  logic [GRID_COLS-1:0] cur_row;
  logic [GRID_COLS-1:0] incoming;
  logic [GRID_COLS-1:0] unit_row;
  logic [31:0]     gen;
  logic [1:0]      op_q;
  logic [RW-1:0]   row_q;
  logic [CW-1:0]   col_q;
  logic            inside_q;
  logic            req_inside;

  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [GRID_COLS-1:0] mem_wdata;
  logic [RW-1:0]        mem_raddr;
  logic [GRID_COLS-1:0] mem_rdata;
  logic                 cell_old;
  logic                 cell_new;

  assign req_ready  = (state == S_IDLE);
  assign req_inside = (32'(req.row_index) < 32'(GRID_ROWS))
                   && (32'(req.col_index) < 32'(GRID_COLS));

  // During the sweep the word read last cycle is the row just below the window.
  assign incoming = (step != '0 && step <= ROWS_S) ? mem_rdata : '0;

  assign cell_old = mem_rdata[col_q];
  assign cell_new = (op_q == OP_TOGGLE) ? !cell_old : cell_old;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = mem_rdata ^ (GRID_COLS'(1) << col_q);
    mem_raddr = row_q;
    if (state == S_SWEEP) begin
      mem_raddr = (step < ROWS_S) ? RW'(step) : '0;
      mem_we    = (step >= WRITE_LAG);
      mem_waddr = RW'(step - WRITE_LAG);
      mem_wdata = unit_row;
    end else if (state == S_CELL) begin
      mem_we = (op_q == OP_TOGGLE) && inside_q;
    end
  end

  lage_grid_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lage_row_unit #(
    .COLS (GRID_COLS)
  ) u_row (
    .row_above (prev_row),
    .row_mid   (cur_row),
    .row_below (incoming),
    .row_next  (unit_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen       <= '0;
      rsp_valid <= 1'b0;
      step      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q     <= req.op;
            row_q    <= req_inside ? RW'(req.row_index) : '0;
            col_q    <= req_inside ? CW'(req.col_index) : '0;
            inside_q <= req_inside;
            step     <= '0;
            prev_row <= '0;
            cur_row  <= '0;
            state    <= (req.op == OP_ADVANCE) ? S_SWEEP : S_READ;
          end
        end
        S_SWEEP: begin
          step <= step + SW'(1);
          if (step != '0) begin
            prev_row <= cur_row;
            cur_row  <= incoming;
          end
          if (step == SWEEP_LAST) begin
            gen   <= gen + 32'd1;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CELL;
        end
        S_CELL: begin
          rsp.cell_alive       <= inside_q && cell_new;
          rsp.generation_count <= gen;
          rsp_valid            <= 1'b1;
          state                <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
